@@ rtl/spam_pkg.sv @@
package spam_pkg;

  localparam int unsigned COORD_W     = 32;
  localparam int unsigned SPAN_W      = 33;
  localparam int unsigned SCALE_W     = 48;
  localparam int unsigned PROD_W      = SCALE_W + SPAN_W;
  localparam int unsigned PIX_W       = 16;
  localparam int unsigned TOT_SHIFT   = 32;
  localparam int unsigned DIV_STEPS   = SCALE_W;
  localparam int unsigned MUL_STEPS   = SPAN_W;
  localparam int unsigned CNT_W       = 6;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned RECIP_SHIFT = 34;

  localparam logic [PIX_W-1:0]   DEFAULT_LONG_SIDE = 16'd1024;
  localparam logic [COORD_W-1:0] COORD_ONE         = 32'h0001_0000;
  localparam logic [SCALE_W-1:0] RECIP5            = 48'd3435973837;

  localparam logic [1:0] OP_BOUND = 2'd0;
  localparam logic [1:0] OP_FIT   = 2'd1;
  localparam logic [1:0] OP_PLOT  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_VIEW_XL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_YL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_XH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_YH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_W   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMG_H   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LONG    = 3'd6;

  localparam logic [3:0] JOB_OX   = 4'd0;
  localparam logic [3:0] JOB_OY   = 4'd1;
  localparam logic [3:0] JOB_SX   = 4'd4;
  localparam logic [3:0] JOB_SY   = 4'd5;
  localparam logic [3:0] JOB_SA   = 4'd6;
  localparam logic [3:0] JOB_SIZE = 4'd7;
  localparam logic [3:0] JOB_PX   = 4'd8;
  localparam logic [3:0] JOB_PY   = 4'd9;

  typedef struct packed {
    logic       fit_load;
    logic       plot_load;
    logic       bound;
    logic       clear;
    logic       div_go;
    logic       div_store;
    logic       mul_go;
    logic       mul_store;
    logic       emit;
    logic       emit_plot;
    logic [3:0] job;
  } cmd_t;

  typedef struct packed {
    logic fixed_size;
    logic div_done;
    logic mul_done;
  } stat_t;

endpackage

@@ rtl/spam_div.sv @@
module spam_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             go,
  input  logic [spam_pkg::SCALE_W-1:0]     dividend,
  input  logic [spam_pkg::SPAN_W-1:0]      divisor,
  output logic                             done,
  output logic [spam_pkg::SCALE_W-1:0]     quotient
);

  logic                           busy_r;
  logic                           done_r;
  logic [spam_pkg::CNT_W-1:0]     cnt_r;
  logic [spam_pkg::SPAN_W-1:0]    rem_r;
  logic [spam_pkg::SPAN_W-1:0]    dsr_r;
  logic [spam_pkg::SCALE_W-1:0]   quo_r;
  logic [spam_pkg::SPAN_W:0]      shifted;
  logic [spam_pkg::SPAN_W+1:0]    diff;
  logic                           ge;

  assign shifted = {rem_r, quo_r[spam_pkg::SCALE_W-1]};
  assign diff    = {1'b0, shifted} - {2'b00, dsr_r};
  assign ge      = ~diff[spam_pkg::SPAN_W+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == spam_pkg::CNT_W'(spam_pkg::DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem_r <= '0;
      quo_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[spam_pkg::SPAN_W-1:0] : shifted[spam_pkg::SPAN_W-1:0];
      quo_r <= {quo_r[spam_pkg::SCALE_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

@@ rtl/spam_mul.sv @@
module spam_mul (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           go,
  input  logic [spam_pkg::SCALE_W-1:0]   a,
  input  logic [spam_pkg::SPAN_W-1:0]    b,
  output logic                           done,
  output logic [spam_pkg::PROD_W-1:0]    prod
);

  logic                           busy_r;
  logic                           done_r;
  logic [spam_pkg::CNT_W-1:0]     cnt_r;
  logic [spam_pkg::SCALE_W-1:0]   a_r;
  logic [spam_pkg::SPAN_W-1:0]    b_r;
  logic [spam_pkg::PROD_W-1:0]    acc_r;
  logic [spam_pkg::PROD_W-1:0]    acc_nxt;

  assign acc_nxt = {acc_r[spam_pkg::PROD_W-2:0], 1'b0}
                 + (b_r[spam_pkg::SPAN_W-1] ? {{spam_pkg::SPAN_W{1'b0}}, a_r}
                                            : {spam_pkg::PROD_W{1'b0}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (go) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == spam_pkg::CNT_W'(spam_pkg::MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      a_r   <= a;
      b_r   <= b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      b_r   <= {b_r[spam_pkg::SPAN_W-2:0], 1'b0};
    end
  end

  assign done = done_r;
  assign prod = acc_r;

endmodule

@@ rtl/spam_dp.sv @@
module spam_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  spam_pkg::cmd_t                      cmd,
  output spam_pkg::stat_t                     stat,
  input  logic [spam_pkg::COORD_W-1:0]        in_coord_x,
  input  logic [spam_pkg::COORD_W-1:0]        in_coord_y,
  input  logic [31:0]                         in_point_color,
  input  logic                                cfg_we,
  input  logic [spam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_wdata,
  output logic                                out_valid,
  output logic                                out_result_kind,
  output logic [15:0]                         out_width,
  output logic [15:0]                         out_height,
  output logic [15:0]                         out_column,
  output logic [15:0]                         out_row,
  output logic [31:0]                         out_pixel_color,
  output logic                                out_inside_res
);

  localparam int unsigned CW = spam_pkg::COORD_W;
  localparam int unsigned SW = spam_pkg::SPAN_W;
  localparam int unsigned KW = spam_pkg::SCALE_W;
  localparam int unsigned PW = spam_pkg::PIX_W;

  logic [CW-1:0] vxl_r, vyl_r, vxh_r, vyh_r;
  logic [PW-1:0] imw_r, imh_r, lng_r;

  logic [CW-1:0] min_x_r, max_x_r, min_y_r, max_y_r;
  logic          have_r;
  logic [CW-1:0] org_x_r, org_y_r;
  logic [KW-1:0] scl_x_r, scl_y_r;
  logic [PW-1:0] fw_r, fh_r;
  logic [CW-1:0] lx_r, ly_r, sx_r, sy_r;
  logic [SW-1:0] ux_r, uy_r;
  logic [CW-1:0] px_r, py_r, color_r;
  logic [PW-1:0] col_r, row_r;
  logic          inx_r, iny_r;

  logic          out_valid_r, out_kind_r, out_in_r;
  logic [PW-1:0] out_w_r, out_h_r, out_c_r, out_rw_r;
  logic [31:0]   out_col_r;

  logic          view_ok;
  logic [CW-1:0] sel_lx, sel_ly, sel_hx, sel_hy;
  logic [SW-1:0] dif_x, dif_y;
  logic [CW-1:0] spn_x, spn_y;
  logic [PW-1:0] k_side;
  logic          x_long, fixed_size;

  logic [KW-1:0] div_dvd, div_q;
  logic [SW-1:0] div_dsr;
  logic          div_done;
  logic [KW-1:0] mul_a;
  logic [SW-1:0] mul_b;
  logic [spam_pkg::PROD_W-1:0] mul_p;
  logic          mul_done;

  logic [CW+1:0] org_dif;
  logic [CW-1:0] org_sat;
  logic [CW-1:0] org_lo;
  logic [CW-1:0] org_spn;
  logic [CW-1:0] q5;
  logic [SW-1:0] u_sum;
  logic [SW-1:0] d_x, d_y, mag_x, mag_y;
  logic [KW:0]   p_sh;
  logic [PW-1:0] p_sz;
  logic          p_in;

  assign view_ok = ($signed(vxh_r) > $signed(vxl_r)) && ($signed(vyh_r) > $signed(vyl_r));
  assign fixed_size = (imw_r != '0) && (imh_r != '0);
  assign k_side = (lng_r != '0) ? lng_r : spam_pkg::DEFAULT_LONG_SIDE;
  assign x_long = ux_r >= uy_r;

  always_comb begin
    if (view_ok) begin
      sel_lx = vxl_r; sel_ly = vyl_r; sel_hx = vxh_r; sel_hy = vyh_r;
    end else if (have_r) begin
      sel_lx = min_x_r; sel_ly = min_y_r; sel_hx = max_x_r; sel_hy = max_y_r;
    end else begin
      sel_lx = '0; sel_ly = '0; sel_hx = '0; sel_hy = '0;
    end
    dif_x = {sel_hx[CW-1], sel_hx} - {sel_lx[CW-1], sel_lx};
    dif_y = {sel_hy[CW-1], sel_hy} - {sel_ly[CW-1], sel_ly};
    spn_x = (dif_x[SW-1] || dif_x == '0) ? spam_pkg::COORD_ONE : dif_x[CW-1:0];
    spn_y = (dif_y[SW-1] || dif_y == '0) ? spam_pkg::COORD_ONE : dif_y[CW-1:0];
  end

  always_comb begin
    div_dvd = '0;
    div_dsr = SW'(1);
    unique case (cmd.job)
      spam_pkg::JOB_SX: begin
        div_dvd = {imw_r, {spam_pkg::TOT_SHIFT{1'b0}}}; div_dsr = ux_r;
      end
      spam_pkg::JOB_SY: begin
        div_dvd = {imh_r, {spam_pkg::TOT_SHIFT{1'b0}}}; div_dsr = uy_r;
      end
      spam_pkg::JOB_SA: begin
        div_dvd = {k_side, {spam_pkg::TOT_SHIFT{1'b0}}};
        div_dsr = x_long ? ux_r : uy_r;
      end
      default: begin
        div_dvd = '0; div_dsr = SW'(1);
      end
    endcase
  end

  assign d_x   = {px_r[CW-1], px_r} - {org_x_r[CW-1], org_x_r};
  assign d_y   = {py_r[CW-1], py_r} - {org_y_r[CW-1], org_y_r};
  assign mag_x = d_x[SW-1] ? (~d_x + 1'b1) : d_x;
  assign mag_y = d_y[SW-1] ? (~d_y + 1'b1) : d_y;

  always_comb begin
    mul_a = scl_x_r;
    mul_b = x_long ? uy_r : ux_r;
    unique case (cmd.job)
      spam_pkg::JOB_OX: begin
        mul_a = spam_pkg::RECIP5; mul_b = {1'b0, sx_r};
      end
      spam_pkg::JOB_OY: begin
        mul_a = spam_pkg::RECIP5; mul_b = {1'b0, sy_r};
      end
      spam_pkg::JOB_PX: begin
        mul_a = scl_x_r; mul_b = mag_x;
      end
      spam_pkg::JOB_PY: begin
        mul_a = scl_y_r; mul_b = mag_y;
      end
      default: begin
        mul_a = scl_x_r; mul_b = x_long ? uy_r : ux_r;
      end
    endcase
  end

  spam_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .go       (cmd.div_go),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .done     (div_done),
    .quotient (div_q)
  );

  spam_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.mul_go),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  // span / 5 by reciprocal, exact for any 32-bit span
  assign q5      = mul_p[spam_pkg::RECIP_SHIFT +: CW];
  assign org_lo  = (cmd.job == spam_pkg::JOB_OY) ? ly_r : lx_r;
  assign org_spn = (cmd.job == spam_pkg::JOB_OY) ? sy_r : sx_r;
  assign u_sum   = {1'b0, org_spn} + {1'b0, q5};
  assign org_dif = {org_lo[CW-1], org_lo[CW-1], org_lo} - {3'b000, q5[CW-1:1]};
  always_comb begin
    if ($signed(org_dif) > $signed({2'b00, 1'b0, {(CW-1){1'b1}}})) begin
      org_sat = {1'b0, {(CW-1){1'b1}}};
    end else if ($signed(org_dif) < $signed({2'b11, 1'b1, {(CW-1){1'b0}}})) begin
      org_sat = {1'b1, {(CW-1){1'b0}}};
    end else begin
      org_sat = org_dif[CW-1:0];
    end
  end

  assign p_sh = mul_p[spam_pkg::PROD_W-1:spam_pkg::TOT_SHIFT];
  assign p_sz = (p_sh[KW:PW] != '0) ? {PW{1'b1}} : p_sh[PW-1:0];
  always_comb begin
    if (cmd.job == spam_pkg::JOB_PY) begin
      p_in = !(d_y[SW-1] && p_sh != '0) && (p_sh < (KW+1)'(fh_r));
    end else begin
      p_in = !(d_x[SW-1] && p_sh != '0) && (p_sh < (KW+1)'(fw_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vxl_r <= '0; vyl_r <= '0; vxh_r <= '0; vyh_r <= '0;
      imw_r <= '0; imh_r <= '0; lng_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spam_pkg::REG_VIEW_XL: vxl_r <= cfg_wdata;
        spam_pkg::REG_VIEW_YL: vyl_r <= cfg_wdata;
        spam_pkg::REG_VIEW_XH: vxh_r <= cfg_wdata;
        spam_pkg::REG_VIEW_YH: vyh_r <= cfg_wdata;
        spam_pkg::REG_IMG_W:   imw_r <= cfg_wdata[PW-1:0];
        spam_pkg::REG_IMG_H:   imh_r <= cfg_wdata[PW-1:0];
        spam_pkg::REG_LONG:    lng_r <= cfg_wdata[PW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_x_r <= '0; max_x_r <= '0; min_y_r <= '0; max_y_r <= '0;
      have_r  <= 1'b0;
      org_x_r <= '0; org_y_r <= '0;
      scl_x_r <= '0; scl_y_r <= '0;
      fw_r    <= '0; fh_r    <= '0;
    end else begin
      if (cmd.clear) begin
        min_x_r <= '0; max_x_r <= '0; min_y_r <= '0; max_y_r <= '0;
        have_r  <= 1'b0;
      end else if (cmd.bound) begin
        have_r <= 1'b1;
        if (!have_r || $signed(in_coord_x) < $signed(min_x_r)) min_x_r <= in_coord_x;
        if (!have_r || $signed(in_coord_x) > $signed(max_x_r)) max_x_r <= in_coord_x;
        if (!have_r || $signed(in_coord_y) < $signed(min_y_r)) min_y_r <= in_coord_y;
        if (!have_r || $signed(in_coord_y) > $signed(max_y_r)) max_y_r <= in_coord_y;
      end
      if (cmd.div_store) begin
        unique case (cmd.job)
          spam_pkg::JOB_SX: begin
            scl_x_r <= div_q; fw_r <= imw_r;
          end
          spam_pkg::JOB_SY: begin
            scl_y_r <= div_q; fh_r <= imh_r;
          end
          spam_pkg::JOB_SA: begin
            scl_x_r <= div_q; scl_y_r <= div_q;
            if (x_long) fw_r <= k_side;
            else        fh_r <= k_side;
          end
          default: ;
        endcase
      end
      if (cmd.mul_store) begin
        unique case (cmd.job)
          spam_pkg::JOB_OX: org_x_r <= org_sat;
          spam_pkg::JOB_OY: org_y_r <= org_sat;
          spam_pkg::JOB_SIZE: begin
            if (x_long) fh_r <= p_sz;
            else        fw_r <= p_sz;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fit_load) begin
      lx_r <= sel_lx; ly_r <= sel_ly; sx_r <= spn_x; sy_r <= spn_y;
    end
    if (cmd.mul_store && cmd.job == spam_pkg::JOB_OX) ux_r <= u_sum;
    if (cmd.mul_store && cmd.job == spam_pkg::JOB_OY) uy_r <= u_sum;
    if (cmd.plot_load) begin
      px_r <= in_coord_x; py_r <= in_coord_y; color_r <= in_point_color;
    end
    if (cmd.mul_store && cmd.job == spam_pkg::JOB_PX) begin
      col_r <= p_sh[PW-1:0]; inx_r <= p_in;
    end
    if (cmd.mul_store && cmd.job == spam_pkg::JOB_PY) begin
      row_r <= p_sh[PW-1:0]; iny_r <= p_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (cmd.emit_plot) begin
        out_kind_r <= 1'b1;
        out_w_r    <= '0;
        out_h_r    <= '0;
        out_in_r   <= inx_r & iny_r;
        out_c_r    <= (inx_r & iny_r) ? col_r : '0;
        out_rw_r   <= (inx_r & iny_r) ? row_r : '0;
        out_col_r  <= color_r;
      end else begin
        out_kind_r <= 1'b0;
        out_w_r    <= fw_r;
        out_h_r    <= fh_r;
        out_in_r   <= 1'b0;
        out_c_r    <= '0;
        out_rw_r   <= '0;
        out_col_r  <= '0;
      end
    end
  end

  assign stat.fixed_size = fixed_size;
  assign stat.div_done   = div_done;
  assign stat.mul_done   = mul_done;

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_width       = out_w_r;
  assign out_height      = out_h_r;
  assign out_column      = out_c_r;
  assign out_row         = out_rw_r;
  assign out_pixel_color = out_col_r;
  assign out_inside_res  = out_in_r;

endmodule

@@ rtl/spam_ctrl.sv @@
module spam_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [1:0]       in_op,
  output logic             busy,
  input  spam_pkg::stat_t  stat,
  output spam_pkg::cmd_t   cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DGO  = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_MGO  = 3'd3;
  localparam logic [2:0] ST_MUL  = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic [3:0] job_r, job_nxt;
  logic       plot_r, plot_nxt;
  logic       accept;

  assign accept = start && (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    job_nxt   = job_r;
    plot_nxt  = plot_r;
    cmd       = '0;
    cmd.job   = job_r;
    cmd.emit_plot = plot_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_op)
            spam_pkg::OP_BOUND: cmd.bound = 1'b1;
            spam_pkg::OP_CLEAR: cmd.clear = 1'b1;
            spam_pkg::OP_FIT: begin
              cmd.fit_load = 1'b1;
              job_nxt      = spam_pkg::JOB_OX;
              plot_nxt     = 1'b0;
              state_nxt    = ST_MGO;
            end
            spam_pkg::OP_PLOT: begin
              cmd.plot_load = 1'b1;
              job_nxt       = spam_pkg::JOB_PX;
              plot_nxt      = 1'b1;
              state_nxt     = ST_MGO;
            end
            default: ;
          endcase
        end
      end
      ST_DGO: begin
        cmd.div_go = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        if (stat.div_done) begin
          cmd.div_store = 1'b1;
          state_nxt     = ST_DGO;
          unique case (job_r)
            spam_pkg::JOB_SX: job_nxt = spam_pkg::JOB_SY;
            spam_pkg::JOB_SY: state_nxt = ST_EMIT;
            spam_pkg::JOB_SA: begin
              job_nxt   = spam_pkg::JOB_SIZE;
              state_nxt = ST_MGO;
            end
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_MGO: begin
        cmd.mul_go = 1'b1;
        state_nxt  = ST_MUL;
      end
      ST_MUL: begin
        if (stat.mul_done) begin
          cmd.mul_store = 1'b1;
          unique case (job_r)
            spam_pkg::JOB_PX: begin
              job_nxt   = spam_pkg::JOB_PY;
              state_nxt = ST_MGO;
            end
            spam_pkg::JOB_OX: begin
              job_nxt   = spam_pkg::JOB_OY;
              state_nxt = ST_MGO;
            end
            spam_pkg::JOB_OY: begin
              job_nxt   = stat.fixed_size ? spam_pkg::JOB_SX : spam_pkg::JOB_SA;
              state_nxt = ST_DGO;
            end
            default: state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_EMIT: begin
        cmd.emit  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      job_r   <= spam_pkg::JOB_OX;
      plot_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      job_r   <= job_nxt;
      plot_r  <= plot_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

  a_long_op_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_op == spam_pkg::OP_FIT || in_op == spam_pkg::OP_PLOT)) |=> busy)
    else $error("fit or plot transfer did not raise busy");

  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> !busy)
    else $error("busy after result");

  a_units_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(stat.div_done && stat.mul_done))
    else $error("divider and multiplier finished together");

endmodule

@@ rtl/scatter_point_autofit_mapper_top.sv @@
// channel   ports                                      transfer
// input     start, busy, in_op, in_coord_x/y, in_point_color  start && !busy
// result    out_valid, out_result_kind ... out_inside_res      out_valid, one cycle
// config    cfg_we, cfg_index, cfg_wdata                       cfg_we
//
// bound and clear keep busy low
// plot takes two passes of the 33-step shift-add multiplier
// fit takes two multiplier passes for the margins, then
// two passes of the 48-step divider, or one divider and one multiplier pass
// when the aspect ratio is kept
// synchronous active-low reset clears bounds, fit origins, scales, sizes and config registers
// the receiver cannot stall; each result is shown for exactly one cycle
module scatter_point_autofit_mapper_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_op,
  input  logic [31:0]                         in_coord_x,
  input  logic [31:0]                         in_coord_y,
  input  logic [31:0]                         in_point_color,
  input  logic                                cfg_we,
  input  logic [spam_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [31:0]                         cfg_wdata,
  output logic                                out_valid,
  output logic                                out_result_kind,
  output logic [15:0]                         out_width,
  output logic [15:0]                         out_height,
  output logic [15:0]                         out_column,
  output logic [15:0]                         out_row,
  output logic [31:0]                         out_pixel_color,
  output logic                                out_inside_res
);

  spam_pkg::cmd_t  cmd;
  spam_pkg::stat_t stat;

  spam_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .in_op (in_op),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  spam_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_coord_x      (in_coord_x),
    .in_coord_y      (in_coord_y),
    .in_point_color  (in_point_color),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_result_kind (out_result_kind),
    .out_width       (out_width),
    .out_height      (out_height),
    .out_column      (out_column),
    .out_row         (out_row),
    .out_pixel_color (out_pixel_color),
    .out_inside_res  (out_inside_res)
  );

endmodule
